// ===== rtl/jets_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jets_pkg
// shared types, register codes and reset values of the julia escape-time core
// ----------------------------------------------------------------------------
package jets_pkg;

	localparam int DEF_SCREEN_WIDTH  = 512;
	localparam int DEF_SCREEN_HEIGHT = 512;
	localparam int DEF_FRACTION_BITS = 28;

	localparam int PIX_W     = 9;
	localparam int COORD_W   = 32;
	localparam int PROD_W    = 64;
	localparam int CFG_IDX_W = 2;
	localparam int ITER_W    = 8;
	localparam int CHAN_W    = 8;

	localparam logic [ITER_W-1:0] MAX_ITERS = 8'd255;

	// configuration register reset values
	localparam logic signed [31:0] RST_C_REAL       = 32'sd107374182;
	localparam logic signed [31:0] RST_C_IMAG       = 32'sd53687091;
	localparam logic [30:0]        RST_PIXEL_STEP   = 31'd1048576;
	localparam logic [30:0]        RST_ESCAPE_LIMIT = 31'd1073741824;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C_REAL       = 2'd0,
		REG_C_IMAG       = 2'd1,
		REG_PIXEL_STEP   = 2'd2,
		REG_ESCAPE_LIMIT = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_LOAD,
		ST_MUL,
		ST_UPD,
		ST_COLOR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_pix;
		logic sel_init;
		logic load_z;
		logic upd;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
		logic escaped;
	} stat_t;

	typedef struct packed {
		logic [ITER_W-1:0] iterations;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              colour_valid;
	} result_t;

endpackage

// ===== rtl/julia_escape_time_pixel_core.sv =====
`timescale 1ns / 1ps
// flow: an accepted item passes ST_INIT, ST_LOAD, the square/update loop (ST_MUL, ST_UPD)
//   and ST_COLOR, and the output register then raises m_tvalid
// items: a new item is taken only in ST_IDLE, once the last one has gone to the output register;
//   the multiply/update loop runs on the one shared set of three 32x32 multipliers
// reset: arst_n clears the sequencer and output valid and loads the register reset values
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_core
// julia-set escape count and band colour for one pixel coordinate per item
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_core import jets_pkg::*; #(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // pix_x[8:0], pix_y[17:9], zero pad
	// result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // iterations, red, green, blue
	output logic                 m_tuser,   // colour_valid
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	// configuration registers
	logic signed [COORD_W-1:0] c_real_q, c_imag_q;
	logic [30:0]               pixel_step_q, escape_limit_q;

	// output register, parts the loop from the downstream side
	logic    m_tvalid_q;
	result_t res_q;

	cmd_t    cmd;
	stat_t   stat;
	result_t res;
	logic    out_free, out_load;

	// writes are taken whenever cfg_valid is high, so the port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q       <= RST_C_REAL;
			c_imag_q       <= RST_C_IMAG;
			pixel_step_q   <= RST_PIXEL_STEP;
			escape_limit_q <= RST_ESCAPE_LIMIT;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_C_REAL:       c_real_q       <= $signed(cfg_data);
				REG_C_IMAG:       c_imag_q       <= $signed(cfg_data);
				REG_PIXEL_STEP:   pixel_step_q   <= cfg_data[30:0];
				REG_ESCAPE_LIMIT: escape_limit_q <= cfg_data[30:0];
			endcase
		end
	end

	jets_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.out_free (out_free),
		.out_load (out_load),
		.cmd      (cmd)
	);

	jets_dpath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.pix_x        (s_tdata[8:0]),
		.pix_y        (s_tdata[17:9]),
		.c_real       (c_real_q),
		.c_imag       (c_imag_q),
		.pixel_step   (pixel_step_q),
		.escape_limit (escape_limit_q),
		.stat         (stat),
		.res          (res)
	);

	// free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {res_q.blue, res_q.green, res_q.red, res_q.iterations};
	assign m_tuser  = res_q.colour_valid;

endmodule

// ===== rtl/jets_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jets_dpath
// start point, shared complex square unit, escape test and colour bands
// ----------------------------------------------------------------------------
module jets_dpath import jets_pkg::*; #(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic [PIX_W-1:0]          pix_x,
	input  logic [PIX_W-1:0]          pix_y,
	input  logic signed [COORD_W-1:0] c_real,
	input  logic signed [COORD_W-1:0] c_imag,
	input  logic [30:0]               pixel_step,
	input  logic [30:0]               escape_limit,
	output stat_t                     stat,
	output result_t                   res
);

	localparam logic signed [COORD_W-1:0] HALF_W = COORD_W'(SCREEN_WIDTH / 2);
	localparam logic signed [COORD_W-1:0] HALF_H = COORD_W'(SCREEN_HEIGHT / 2);

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[COORD_W-1:0];
		return r;
	endfunction

	function automatic result_t colour_map(input logic [ITER_W-1:0] it);
		result_t     r;
		logic [10:0] t;
		logic [10:0] t5;
		logic [19:0] b3;
		r = '0;
		r.iterations = it;
		r.colour_valid = 1'b1;
		t = '0;
		t5 = '0;
		b3 = '0;
		if (it <= 8'd76) begin
			// i*10/3 as multiply by 683/2048
			b3 = 20'(it) * 20'd10 * 20'd683;
			r.blue = 8'(b3 >> 11);
		end else if (it <= 8'd178) begin
			t = {2'b00, it, 1'b0} - 11'd153;
			t5 = 11'(t * 11'd5);
			r.green = 8'(t5 >> 2);
			r.blue = 8'd255 - r.green;
		end else if (it <= 8'd229) begin
			t = {2'b00, it, 1'b0} - 11'd357;
			t5 = 11'(t * 11'd5);
			r.red = 8'(t5 >> 1);
			r.green = 8'd255 - r.red;
		end else if (it < MAX_ITERS) begin
			t = {2'b00, it, 1'b0} - 11'd459;
			t5 = 11'(t * 11'd5);
			r.red = 8'd255;
			r.green = 8'(t5);
			r.blue = 8'(t5);
		end else begin
			r.colour_valid = 1'b0;
		end
		return r;
	endfunction

	logic [PIX_W-1:0]          pix_x_q, pix_y_q;
	logic signed [COORD_W-1:0] re_q, im_q;
	logic signed [PROD_W-1:0]  p_rr_q, p_ii_q, p_ri_q;
	logic [ITER_W-1:0]         cnt_q;
	logic [ITER_W-1:0]         iter_q;

	logic signed [COORD_W-1:0] step_s, dx, dy;
	logic signed [COORD_W-1:0] op_a0, op_b0, op_a1, op_b1;
	logic signed [PROD_W-1:0]  diff, re_sum, im_sum;
	logic [PROD_W-1:0]         len2;
	logic                      escaped;

	assign step_s = $signed({1'b0, pixel_step});
	assign dy = HALF_H - $signed({{(COORD_W-PIX_W){1'b0}}, pix_y_q});
	assign dx = $signed({{(COORD_W-PIX_W){1'b0}}, pix_x_q}) - HALF_W;

	// the square unit also forms the start point
	assign op_a0 = cmd.sel_init ? step_s : re_q;
	assign op_b0 = cmd.sel_init ? dy     : re_q;
	assign op_a1 = cmd.sel_init ? step_s : im_q;
	assign op_b1 = cmd.sel_init ? dx     : im_q;

	always_ff @(posedge clk) begin
		p_rr_q <= op_a0 * op_b0;
		p_ii_q <= op_a1 * op_b1;
		p_ri_q <= re_q * im_q;
	end

	// escape test uses the squares of the current point
	assign len2 = ($unsigned(p_rr_q) + $unsigned(p_ii_q)) >> FRACTION_BITS;
	assign escaped = (cnt_q != '0) && (len2 > {33'b0, escape_limit});

	assign diff   = p_rr_q - p_ii_q;
	assign re_sum = (diff >>> FRACTION_BITS) + $signed({{32{c_real[31]}}, c_real});
	assign im_sum = (p_ri_q >>> (FRACTION_BITS - 1)) + $signed({{32{c_imag[31]}}, c_imag});

	assign stat.escaped = escaped;
	assign stat.done    = escaped || (cnt_q == MAX_ITERS);

	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			pix_x_q <= pix_x;
			pix_y_q <= pix_y;
		end
		if (cmd.load_z) begin
			re_q <= sat32(p_rr_q);
			im_q <= sat32(p_ii_q);
		end else if (cmd.upd && !stat.done) begin
			re_q <= sat32(re_sum);
			im_q <= sat32(im_sum);
		end
		if (cmd.upd && stat.done)
			iter_q <= escaped ? cnt_q - 8'd1 : MAX_ITERS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_z) begin
			cnt_q <= '0;
		end else if (cmd.upd && !stat.done) begin
			cnt_q <= cnt_q + 8'd1;
		end
	end

	assign res = colour_map(iter_q);

`ifndef ASSERT_OFF
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && !stat.done) |=> (cnt_q == $past(cnt_q) + 8'd1))
		else $error("iteration count did not advance by one");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && cnt_q == MAX_ITERS) |-> stat.done)
		else $error("iteration ran past the cap");
	a_escape_done: assert property (@(posedge clk) disable iff (!arst_n)
		stat.escaped |-> stat.done)
		else $error("escape without done");
`endif

endmodule

// ===== rtl/jets_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jets_ctrl
// sequencer for one pixel: start point, square/update loop, colour hand-off
// ----------------------------------------------------------------------------
module jets_ctrl import jets_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	input  logic  out_free,
	output logic  out_load,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_pix = 1'b1;
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.sel_init = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_z = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = stat.done ? ST_COLOR : ST_MUL;
			end
			ST_COLOR: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_upd_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> ($past(state_q) == ST_MUL))
		else $error("update without fresh products");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");
	a_accept_init: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_INIT))
		else $error("accepted item not started");
`endif

endmodule
